>>> hw/rtl/qep_pkg.sv
// Shared types, codes and helpers for the quadrature encoder position block.
package qep_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_EDGE_A = 2'd0,
        OP_EDGE_B = 2'd1,
        OP_TICK   = 2'd2,
        OP_READ   = 2'd3
    } t_qep_op;

    // Configuration register indexes
    localparam logic [1:0] CFG_RANGE_MAX = 2'd0;
    localparam logic [1:0] CFG_START_POS = 2'd1;
    localparam logic [1:0] CFG_ROLL_OVER = 2'd2;
    localparam logic [1:0] CFG_COOLDOWN  = 2'd3;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int TIME_W      = 32;
    localparam int COOLDOWN_W  = 16;
    localparam int RANGE_RESET = 255;

    // Phase codes and step masks
    localparam logic [1:0] PHASE_ZERO = 2'b00;
    localparam logic [1:0] PHASE_A    = 2'b01;
    localparam logic [1:0] PHASE_B    = 2'b11;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_ADJ,
        S_FIN
    } t_qep_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic edge_a;
        logic edge_b;
        logic tick;
        logic rd_start;
        logic div_step;
        logic adjust;
        logic finish;
    } t_qep_cmd;

    // Phase from pin levels: (b,a) 00,01,11,10 -> 0,1,2,3
    function automatic logic [1:0] pins_to_phase(input logic pin_b, input logic pin_a);
        logic [1:0] ph;
        unique case ({pin_b, pin_a})
            2'b00:   ph = 2'd0;
            2'b01:   ph = 2'd1;
            2'b11:   ph = 2'd2;
            default: ph = 2'd3;
        endcase
        return ph;
    endfunction

endpackage

>>> hw/rtl/qep_ctrl.sv
// Controller state machine: item acceptance, read sequencing, result register valid.
module qep_ctrl
    import qep_pkg::*;
#(
    parameter int PENDING_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_qep_op  i_op,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_qep_cmd o_cmd
);

    localparam int CNT_W = $clog2(PENDING_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PENDING_WIDTH - 1);

    t_qep_state       r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             w_in_acc;
    logic             w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_op == OP_READ) n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_ADJ;
            end
            S_ADJ: n_state = S_FIN;
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_op)
                        OP_EDGE_A: o_cmd.edge_a   = 1'b1;
                        OP_EDGE_B: o_cmd.edge_b   = 1'b1;
                        OP_TICK:   o_cmd.tick     = 1'b1;
                        OP_READ:   o_cmd.rd_start = 1'b1;
                        default:   o_cmd          = '0;
                    endcase
                end
            end
            S_DIV:   o_cmd.div_step = 1'b1;
            S_ADJ:   o_cmd.adjust   = 1'b1;
            S_FIN:   o_cmd.finish   = w_out_free;
            default: o_cmd          = '0;
        endcase
    end

    // State, step counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.rd_start) begin
                r_cnt <= CNT_LAST;
            end else if (o_cmd.div_step) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_read_enters_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_op == OP_READ) |=> (r_state == S_DIV))
        else $error("read item did not start the division");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_ADJ))
        else $error("division did not end after its last step");

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result valid raised outside the finish state");

endmodule

>>> hw/rtl/qep_dp.sv
// Datapath: config registers, edge counting, bit-serial modulo and position update.
module qep_dp
    import qep_pkg::*;
#(
    parameter int POSITION_WIDTH = 32,
    parameter int PENDING_WIDTH  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_pin_a,
    input  logic                      i_pin_b,
    input  t_qep_cmd                  i_cmd,
    output logic [POSITION_WIDTH-1:0] o_position_out,
    output logic                      o_hit_limit
);

    localparam int PW = POSITION_WIDTH;
    localparam int QW = PENDING_WIDTH;
    localparam int NW = POSITION_WIDTH + 2;

    localparam logic [QW-1:0] PEND_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] PEND_MIN = {1'b1, {(QW-1){1'b0}}};

    // Control state
    logic [PW-1:0]         r_range, r_start, r_pos;
    logic                  r_roll;
    logic [COOLDOWN_W-1:0] r_cool;
    logic [1:0]            r_phase;
    logic [QW-1:0]         r_pend;
    logic [TIME_W-1:0]     r_ms, r_last_a, r_last_b;

    // Read working registers
    logic                  r_sign;
    logic [QW-1:0]         r_quo;
    logic [PW:0]           r_rem;
    logic [NW-1:0]         r_np;
    logic [PW-1:0]         r_out_pos;
    logic                  r_out_hit;

    logic [PW:0]           w_mod;
    logic [NW-1:0]         w_trial, w_diff;
    logic [PW:0]           w_rem_next;
    logic [QW-1:0]         w_mag;
    logic [NW-1:0]         w_np, w_over_d, w_under_w;
    logic                  w_under, w_over;
    logic [PW-1:0]         w_new_pos;
    logic                  w_ok_a, w_ok_b;
    logic [QW-1:0]         w_pend_up, w_pend_dn;
    logic [PW-1:0]         w_cfg_range, w_cfg_start, w_reload;

    assign w_mod = {1'b0, r_range} + (PW + 1)'(1);

    // Cooldown checks, modulo 2^32 elapsed time
    assign w_ok_a = (r_ms - r_last_a) >= {{(TIME_W - COOLDOWN_W){1'b0}}, r_cool};
    assign w_ok_b = (r_ms - r_last_b) >= {{(TIME_W - COOLDOWN_W){1'b0}}, r_cool};

    // Saturating pending steps
    assign w_pend_up = (r_pend == PEND_MAX) ? r_pend : r_pend + QW'(1);
    assign w_pend_dn = (r_pend == PEND_MIN) ? r_pend : r_pend - QW'(1);

    // Magnitude of the pending count; the most negative value fits unsigned
    assign w_mag = r_pend[QW-1] ? (~r_pend + QW'(1)) : r_pend;

    // One restoring division step, remainder only
    assign w_trial    = {r_rem, r_quo[QW-1]};
    assign w_diff     = w_trial - {1'b0, w_mod};
    assign w_rem_next = w_diff[NW-1] ? w_trial[PW:0] : w_diff[PW:0];

    // Signed change applied to the position
    assign w_np = r_sign ? ({2'b00, r_pos} - {1'b0, r_rem})
                         : ({2'b00, r_pos} + {1'b0, r_rem});

    // Limit handling
    assign w_under   = r_np[NW-1];
    assign w_over_d  = r_np - {1'b0, w_mod};
    assign w_under_w = r_np + {1'b0, w_mod};
    assign w_over    = !w_under && !w_over_d[NW-1];

    always_comb begin
        if (w_under) begin
            w_new_pos = r_roll ? w_under_w[PW-1:0] : '0;
        end else if (w_over) begin
            w_new_pos = r_roll ? w_over_d[PW-1:0] : r_range;
        end else begin
            w_new_pos = r_np[PW-1:0];
        end
    end

    // Range or start write reloads the position
    assign w_cfg_range = (i_cfg_idx == CFG_RANGE_MAX) ? i_cfg_data[PW-1:0] : r_range;
    assign w_cfg_start = (i_cfg_idx == CFG_START_POS) ? i_cfg_data[PW-1:0] : r_start;
    assign w_reload    = (w_cfg_start <= w_cfg_range) ? w_cfg_start : '0;

    // Control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range  <= PW'(RANGE_RESET);
            r_start  <= '0;
            r_roll   <= 1'b0;
            r_cool   <= '0;
            r_pos    <= '0;
            r_phase  <= PHASE_ZERO;
            r_pend   <= '0;
            r_ms     <= '0;
            r_last_a <= '0;
            r_last_b <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RANGE_MAX: begin
                        r_range <= w_cfg_range;
                        r_pos   <= w_reload;
                    end
                    CFG_START_POS: begin
                        r_start <= w_cfg_start;
                        r_pos   <= w_reload;
                    end
                    CFG_ROLL_OVER: r_roll <= i_cfg_data[0];
                    CFG_COOLDOWN:  r_cool <= i_cfg_data[COOLDOWN_W-1:0];
                    default:       r_roll <= r_roll;
                endcase
            end
            if (i_cmd.edge_a && w_ok_a) begin
                r_pend   <= r_phase[0] ? w_pend_dn : w_pend_up;
                r_phase  <= r_phase ^ PHASE_A;
                r_last_a <= r_ms;
            end
            if (i_cmd.edge_b && w_ok_b) begin
                r_pend   <= r_phase[0] ? w_pend_up : w_pend_dn;
                r_phase  <= r_phase ^ PHASE_B;
                r_last_b <= r_ms;
            end
            if (i_cmd.tick) begin
                r_ms <= r_ms + TIME_W'(1);
            end
            if (i_cmd.rd_start) begin
                r_pend  <= '0;
                r_phase <= pins_to_phase(i_pin_b, i_pin_a);
            end
            if (i_cmd.finish) begin
                r_pos <= w_new_pos;
            end
        end
    end

    // Read working registers and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_sign <= r_pend[QW-1];
            r_quo  <= w_mag;
            r_rem  <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[QW-2:0], 1'b0};
            r_rem <= w_rem_next;
        end
        if (i_cmd.adjust) begin
            r_np <= w_np;
        end
        if (i_cmd.finish) begin
            r_out_pos <= w_new_pos;
            r_out_hit <= w_under || w_over;
        end
    end

    assign o_position_out = r_out_pos;
    assign o_hit_limit    = r_out_hit;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_range)
        else $error("position beyond range_max");

    a_pend_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_start |=> (r_pend == '0))
        else $error("pending count not cleared by read");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> (r_rem <= {1'b0, r_range}))
        else $error("division remainder not below modulus");

endmodule

>>> hw/rtl/quadrature_encoder_position.sv
// Top level of the quadrature encoder position counter.
// Items on the input channel are edges on A or B, millisecond ticks or
// position reads. Edges and ticks produce no result; an edge within
// cooldown_ms ticks of the last counted edge on the same channel is
// dropped. A read is accepted, then runs the bit-serial modulo of the
// pending count by range_max + 1, one bit per cycle, then adjust and
// finish; the finish waits for the result register to empty, and the
// block then accepts the next item while the result is still held. The
// phase starts at 0 after reset, so issue a read first to sync it with
// the pins. Write configuration only while no read is in progress.
module quadrature_encoder_position
    import qep_pkg::*;
#(
    parameter int POSITION_WIDTH = 32,
    parameter int PENDING_WIDTH  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_op,
    input  logic                      i_pin_a,
    input  logic                      i_pin_b,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [POSITION_WIDTH-1:0] o_position_out,
    output logic                      o_hit_limit
);

    t_qep_cmd w_cmd;

    qep_ctrl #(
        .PENDING_WIDTH (PENDING_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (t_qep_op'(i_op)),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    qep_dp #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .PENDING_WIDTH  (PENDING_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_pin_a        (i_pin_a),
        .i_pin_b        (i_pin_b),
        .i_cmd          (w_cmd),
        .o_position_out (o_position_out),
        .o_hit_limit    (o_hit_limit)
    );

endmodule

>>> verif/quadrature_encoder_position_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the quadrature encoder position counter.
module quadrature_encoder_position_tb;
    import qep_pkg::*;

    localparam int POS_W        = 32;
    localparam int PEND_W       = 32;
    // one read: accept, one division step per pending bit, adjust, finish
    localparam int READ_CYCLES  = PEND_W + 3;
    localparam int SETTLE_CYCLES = READ_CYCLES + 8;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             hit;
    } t_pos_result;

    // DUT ports, inputs known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_RANGE_MAX;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_op = OP_TICK;
    logic                  i_pin_a = 1'b0;
    logic                  i_pin_b = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [POS_W-1:0]      o_position_out;
    logic                  o_hit_limit;

    // Encoder state tracked alongside the block
    logic [POS_W-1:0]      exp_range = POS_W'(RANGE_RESET);
    logic [POS_W-1:0]      exp_start = '0;
    logic                  exp_roll = 1'b0;
    logic [COOLDOWN_W-1:0] exp_cool = '0;
    logic [POS_W-1:0]      exp_pos = '0;
    logic [1:0]            exp_phase = PHASE_ZERO;
    logic signed [PEND_W-1:0] exp_pend = '0;
    logic [TIME_W-1:0]     exp_ms = '0;
    logic [TIME_W-1:0]     exp_last_a = '0;
    logic [TIME_W-1:0]     exp_last_b = '0;

    t_pos_result pending_reads[$];

    bit          idle_on = 1'b1;
    int unsigned out_wait = 0;
    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned items_sent = 0;
    int unsigned reads_checked = 0;
    int unsigned hits_seen = 0;
    int unsigned edges_dropped = 0;

    quadrature_encoder_position #(
        .POSITION_WIDTH(POS_W),
        .PENDING_WIDTH (PEND_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_pin_a       (i_pin_a),
        .i_pin_b       (i_pin_b),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_position_out(o_position_out),
        .o_hit_limit   (o_hit_limit)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d reads outstanding",
                     $time, cycles, pending_reads.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: check each accepted item, then draw the next stall
    always @(posedge i_clk) begin : result_check
        t_pos_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reads.size() == 0) begin
                errors++;
                $display("%0t: result with no read outstanding: expected none, got pos %0h hit %0b",
                         $time, o_position_out, o_hit_limit);
            end else begin
                want = pending_reads.pop_front();
                reads_checked++;
                if (o_hit_limit) hits_seen++;
                if (o_position_out !== want.position) begin
                    errors++;
                    $display("%0t: position mismatch: expected %0h, got %0h",
                             $time, want.position, o_position_out);
                end
                if (o_hit_limit !== want.hit) begin
                    errors++;
                    $display("%0t: hit_limit mismatch: expected %0b, got %0b",
                             $time, want.hit, o_hit_limit);
                end
            end
            out_wait = idle_on ? $urandom_range(0, 3) : 0;
        end else if (out_wait != 0) begin
            out_wait--;
        end
        i_out_stall <= (out_wait != 0);
    end

    // Random pin level
    function automatic logic rand_pin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Saturating step of the pending count
    function automatic void count_step(input bit up);
        if (up) begin
            if (exp_pend != {1'b0, {(PEND_W-1){1'b1}}}) exp_pend = exp_pend + 1;
        end else begin
            if (exp_pend != {1'b1, {(PEND_W-1){1'b0}}}) exp_pend = exp_pend - 1;
        end
    endfunction

    // Send one item and update the tracked state once it is taken
    task automatic send_item(input t_qep_op op, input logic pa, input logic pb);
        int unsigned gap;
        longint      modulus;
        longint      change;
        longint      next_pos;
        t_pos_result res;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_pin_a    <= pa;
        i_pin_b    <= pb;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        case (op)
            OP_EDGE_A: begin
                if ((exp_ms - exp_last_a) < exp_cool) begin
                    edges_dropped++;
                end else begin
                    count_step(!exp_phase[0]);
                    exp_phase  = exp_phase ^ 2'b01;
                    exp_last_a = exp_ms;
                end
            end
            OP_EDGE_B: begin
                if ((exp_ms - exp_last_b) < exp_cool) begin
                    edges_dropped++;
                end else begin
                    count_step(exp_phase[0]);
                    exp_phase  = 2'd3 - exp_phase;
                    exp_last_b = exp_ms;
                end
            end
            OP_TICK: exp_ms = exp_ms + 1;
            default: begin
                // remainder truncates toward zero, modulus up to 2^32
                modulus  = longint'(exp_range) + 1;
                change   = longint'(exp_pend) % modulus;
                next_pos = longint'(exp_pos) + change;
                res.hit  = 1'b1;
                if (next_pos < 0) begin
                    next_pos = exp_roll ? next_pos + modulus : 0;
                end else if (next_pos > longint'(exp_range)) begin
                    next_pos = exp_roll ? next_pos - modulus : longint'(exp_range);
                end else begin
                    res.hit = 1'b0;
                end
                exp_pos  = next_pos[POS_W-1:0];
                exp_pend = '0;
                case ({pb, pa})
                    2'b00:   exp_phase = 2'd0;
                    2'b01:   exp_phase = 2'd1;
                    2'b11:   exp_phase = 2'd2;
                    default: exp_phase = 2'd3;
                endcase
                res.position = exp_pos;
                pending_reads.push_back(res);
            end
        endcase
    endtask

    // One count in the given direction, edge chosen from the current phase
    task automatic send_step(input bit up);
        send_item((up == exp_phase[0]) ? OP_EDGE_B : OP_EDGE_A,
                  rand_pin(), rand_pin());
    endtask

    // Hold the input side until every read has returned
    task automatic drain_reads();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reads.size() != 0);
    endtask

    // Drain, then let any trailing edge or tick finish before a write
    task automatic settle_block();
        drain_reads();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_RANGE_MAX: begin
                exp_range = data[POS_W-1:0];
                exp_pos   = (exp_start <= exp_range) ? exp_start : '0;
            end
            CFG_START_POS: begin
                exp_start = data[POS_W-1:0];
                exp_pos   = (exp_start <= exp_range) ? exp_start : '0;
            end
            CFG_ROLL_OVER: exp_roll = data[0];
            default:       exp_cool = data[COOLDOWN_W-1:0];
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly clean bursts in one direction closed by a read, some noise
    task automatic run_random(input int unsigned n);
        int unsigned first;
        int unsigned kind;
        int unsigned len;
        bit          up;
        first = items_sent;
        while (items_sent - first < n) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 19) == 0) drain_reads();
            if (kind <= 6) begin
                up  = 1'($urandom_range(0, 1));
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
                repeat (len) begin
                    if ($urandom_range(0, 3) == 0)
                        send_item(OP_TICK, rand_pin(), rand_pin());
                    send_step(up);
                end
                send_item(OP_READ, rand_pin(), rand_pin());
            end else if (kind == 7) begin
                repeat ($urandom_range(1, 6))
                    send_item(t_qep_op'($urandom_range(0, 3)), rand_pin(), rand_pin());
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 5))
                    send_item(OP_TICK, rand_pin(), rand_pin());
            end else begin
                send_item(OP_READ, rand_pin(), rand_pin());
            end
        end
    endtask

    task automatic run_setting(input logic [31:0] range_v, input logic [31:0] start_v,
                               input logic roll_v, input logic [15:0] cool_v,
                               input int unsigned n);
        settle_block();
        write_reg(CFG_RANGE_MAX, range_v);
        write_reg(CFG_START_POS, start_v);
        write_reg(CFG_ROLL_OVER, {31'd0, roll_v});
        write_reg(CFG_COOLDOWN, {16'd0, cool_v});
        run_random(n);
    endtask

    // Sync read from reset, count up, read again with other pins
    task automatic test_first_read();
        send_item(OP_READ, 1'b0, 1'b0);
        repeat (4) send_step(1'b1);
        send_item(OP_TICK, 1'b1, 1'b1);
        send_item(OP_READ, 1'b1, 1'b0);
    endtask

    // Clamp then wrap past the top, wrap below zero
    task automatic test_limits();
        settle_block();
        write_reg(CFG_START_POS, 32'd254);
        repeat (3) send_step(1'b1);
        send_item(OP_READ, 1'b1, 1'b1);
        settle_block();
        write_reg(CFG_ROLL_OVER, 32'd1);
        write_reg(CFG_START_POS, 32'd254);
        repeat (3) send_step(1'b1);
        send_item(OP_READ, 1'b0, 1'b1);
        repeat (3) send_step(1'b0);
        send_item(OP_READ, 1'b0, 1'b0);
    endtask

    // Edges close together on one channel are dropped
    task automatic test_cooldown();
        settle_block();
        write_reg(CFG_COOLDOWN, 32'd3);
        send_item(OP_EDGE_A, 1'b0, 1'b0);
        repeat (3) send_item(OP_TICK, 1'b0, 1'b0);
        send_item(OP_EDGE_A, 1'b1, 1'b0);
        send_item(OP_EDGE_A, 1'b0, 1'b1);
        send_item(OP_EDGE_B, 1'b1, 1'b1);
        // sender holds off until the block has caught up
        drain_reads();
        send_item(OP_READ, 1'b1, 1'b0);
    endtask

    // Largest cooldown: edges well inside the 65535 tick window are dropped
    task automatic test_long_cooldown();
        settle_block();
        write_reg(CFG_COOLDOWN, 32'd65535);
        idle_on = 1'b0;
        send_item(OP_EDGE_A, 1'b0, 1'b0);
        repeat (20) send_item(OP_TICK, 1'b0, 1'b0);
        send_item(OP_EDGE_A, 1'b0, 1'b0);
        send_item(OP_EDGE_A, 1'b0, 1'b0);
        send_item(OP_EDGE_B, 1'b0, 1'b0);
        send_item(OP_READ, 1'b1, 1'b1);
        idle_on = 1'b1;
    endtask

    // Random bursts over a sweep of register settings
    task automatic test_random_sweep();
        run_setting(32'd255, 32'd0, 1'b0, 16'd0, 90);
        run_setting(32'd255, 32'd128, 1'b1, 16'd0, 90);
        run_setting(32'd0, 32'd0, 1'b0, 16'd0, 90);
        run_setting(32'd0, 32'd5, 1'b1, 16'd1, 90);
        run_setting(32'd7, 32'd3, 1'b1, 16'd1, 90);
        run_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'd0, 90);
        run_setting(32'hFFFF_FFFF, 32'd4, 1'b0, 16'd2, 90);
        idle_on = 1'b0;
        run_setting(32'd12, 32'd12, 1'b0, 16'd0, 90);
        idle_on = 1'b1;
        run_setting($urandom_range(1, 40), $urandom_range(0, 45), rand_pin(),
                    16'($urandom_range(0, 3)), 90);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_first_read();
        test_limits();
        test_cooldown();
        test_long_cooldown();
        test_random_sweep();
        drain_reads();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d items, checked %0d reads (%0d at a limit), %0d edges dropped",
                 items_sent, reads_checked, hits_seen, edges_dropped);
        $display("Ranges from 0 to full width, clamp and wrap, cooldown from 0 to 65535");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
